### rtl/csvfs_pkg.sv
// ----------------------------------------------------------------------------
// csvfs_pkg
// Shared types and constants of the CSV field splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package csvfs_pkg;

	localparam int FIELD_LIMIT = 16;

	// Closed-field counter, able to hold FIELD_LIMIT itself
	localparam int CNT_W = $clog2(FIELD_LIMIT + 1);
	// Working width for limit compares and output masking
	localparam int LIM_W = (CNT_W > 5) ? CNT_W : 5;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;

	localparam int DATA_W = 24;
	localparam int USER_W = 2;

	typedef struct packed {
		logic [4:0] field_count;
		logic       line_end;
		logic       field_end;
		logic [3:0] field_index;
		logic       byte_valid;
		logic [7:0] field_byte;
	} res_t;

endpackage

`default_nettype wire

### rtl/csvfs_parser.sv
// ----------------------------------------------------------------------------
// csvfs_parser
// Line parse state and per-byte result decode for the CSV field splitter.
// ----------------------------------------------------------------------------
`default_nettype none

module csvfs_parser (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 accept,
	input  wire  [7:0]          char_byte,
	input  wire                 end_of_line,
	input  wire  [4:0]          max_fields,
	output logic                push,
	output csvfs_pkg::res_t     res
);
	import csvfs_pkg::*;

	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_PLAIN  = 3'd1;
	localparam logic [2:0] PH_QUOTED = 3'd2;
	localparam logic [2:0] PH_QPEND  = 3'd3;
	localparam logic [2:0] PH_SKIP   = 3'd4;
	localparam logic [2:0] PH_IGNORE = 3'd5;

	logic [2:0]       phase_q, phase_nxt;
	logic [CNT_W-1:0] closed_q, closed_nxt;
	logic [LIM_W-1:0] closed_w, inc_w, lim;
	logic             has_res;
	res_t             r;

	always_comb begin
		if (max_fields == 5'd0) begin
			lim = LIM_W'(1);
		end else if (LIM_W'(max_fields) > LIM_W'(FIELD_LIMIT)) begin
			lim = LIM_W'(FIELD_LIMIT);
		end else begin
			lim = LIM_W'(max_fields);
		end
	end

	assign closed_w = LIM_W'(closed_q);
	assign inc_w    = closed_w + LIM_W'(1);

	always_comb begin
		phase_nxt  = phase_q;
		closed_nxt = closed_q;
		has_res    = 1'b0;
		r          = '0;
		if (end_of_line) begin
			has_res    = 1'b1;
			r.line_end = 1'b1;
			phase_nxt  = PH_START;
			closed_nxt = '0;
			if (phase_q == PH_IGNORE) begin
				r.field_count = closed_w[4:0];
			end else begin
				r.field_end   = 1'b1;
				r.field_index = closed_w[3:0];
				r.field_count = inc_w[4:0];
			end
		end else begin
			unique case (phase_q) inside
				PH_START, PH_PLAIN, PH_QUOTED, PH_QPEND, PH_SKIP: begin
					if (char_byte == CH_COMMA && phase_q != PH_QUOTED) begin
						has_res       = 1'b1;
						r.field_end   = 1'b1;
						r.field_index = closed_w[3:0];
						closed_nxt    = inc_w[CNT_W-1:0];
						phase_nxt     = (inc_w >= lim) ? PH_IGNORE : PH_START;
					end else if (char_byte == CH_QUOTE && phase_q == PH_START) begin
						phase_nxt = PH_QUOTED;
					end else if (char_byte == CH_QUOTE && phase_q == PH_QUOTED) begin
						phase_nxt = PH_QPEND;
					end else if (phase_q == PH_SKIP) begin
						phase_nxt = PH_SKIP;
					end else if (phase_q == PH_QPEND && char_byte != CH_QUOTE) begin
						phase_nxt = PH_SKIP;
					end else begin
						has_res       = 1'b1;
						r.byte_valid  = 1'b1;
						r.field_byte  = char_byte;
						r.field_index = closed_w[3:0];
						if (phase_q == PH_START) begin
							phase_nxt = PH_PLAIN;
						end else if (phase_q == PH_QPEND) begin
							phase_nxt = PH_QUOTED;
						end
					end
				end
				default: begin
					phase_nxt = PH_IGNORE;
				end
			endcase
		end
	end

	assign push = accept & has_res;
	assign res  = r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			closed_q <= '0;
		end else if (accept) begin
			phase_q  <= phase_nxt;
			closed_q <= closed_nxt;
		end
	end

endmodule

`default_nettype wire

### rtl/csvfs_out_buf.sv
// ----------------------------------------------------------------------------
// csvfs_out_buf
// Result register with skid stage between the parser and the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module csvfs_out_buf (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  csvfs_pkg::res_t     res_in,
	output logic                in_ready,
	output logic                out_valid,
	input  wire                 out_ready,
	output csvfs_pkg::res_t     res_out
);
	import csvfs_pkg::*;

	logic main_vld_q, skid_vld_q;
	res_t main_q, skid_q;
	logic take;

	assign take      = main_vld_q & out_ready;
	assign in_ready  = ~skid_vld_q;
	assign out_valid = main_vld_q;
	assign res_out   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!main_vld_q || take) begin
			main_vld_q <= skid_vld_q | push;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_vld_q || take) begin
			main_q <= skid_vld_q ? skid_q : res_in;
		end else if (push) begin
			skid_q <= res_in;
		end
	end

endmodule

`default_nettype wire

### rtl/csv_field_splitter.sv
// ----------------------------------------------------------------------------
// csv_field_splitter
// Splits a CSV line, one byte per item, into quoted or unquoted fields.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one line byte per item in s_tdata; s_tlast marks the
//   end of the line (its data byte is ignored). Master stream gives at most
//   one item per input item: a field data byte, a field close, or the line
//   end with the field count. Opening and closing quotes, bytes after a
//   closing quote and bytes past the field limit give no output item.
//   cfg_valid/cfg_data write the field limit (cfg_ready is always high);
//   write it only while the block is idle.
// Timing:
//   One input item per cycle while s_tready is high. An output item is
//   registered in the result register, or first in the skid entry while
//   the output stalls; the parse state is updated when the input is accepted.
// Reset:
//   arst_n clears the parse state, empties the output stage and sets the
//   field limit to 8.
// Stall:
//   A two-entry output stage absorbs one extra item; s_tready falls only
//   when both entries are full and rises again the cycle after m_tready
//   takes an item.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_splitter (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [4:0]                   cfg_data,     // max_fields
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [7:0]                   s_tdata,      // char_byte
	input  wire                          s_tlast,      // end_of_line
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [csvfs_pkg::DATA_W-1:0] m_tdata,      // field_byte, field_index,
	                                                   // field_count, zero pad
	output logic [csvfs_pkg::USER_W-1:0] m_tuser,      // byte_valid, field_end
	output logic                         m_tlast       // line_end
);
	import csvfs_pkg::*;

	logic [4:0] max_fields_q;
	logic       accept, push;
	res_t       res_new, res_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_fields_q <= 5'd8;
		end else if (cfg_valid) begin
			max_fields_q <= cfg_data;
		end
	end

	assign accept = s_tvalid & s_tready;

	csvfs_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.char_byte   (s_tdata),
		.end_of_line (s_tlast),
		.max_fields  (max_fields_q),
		.push        (push),
		.res         (res_new)
	);

	csvfs_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res_in    (res_new),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res_out   (res_out)
	);

	assign m_tdata = {7'd0, res_out.field_count, res_out.field_index, res_out.field_byte};
	assign m_tuser = {res_out.field_end, res_out.byte_valid};
	assign m_tlast = res_out.line_end;

endmodule

`default_nettype wire

### rtl/csvfs_checker.sv
// ----------------------------------------------------------------------------
// csvfs_checker
// Port-level checks for the CSV field splitter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module csvfs_checker (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tready,
	input  wire                          m_tvalid,
	input  wire                          m_tready,
	input  wire  [csvfs_pkg::DATA_W-1:0] m_tdata,
	input  wire  [csvfs_pkg::USER_W-1:0] m_tuser,
	input  wire                          m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output item changed while stalled");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[16:12] != 5'd0)
		else $error("line end with zero field count");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tuser[1] && !m_tlast && m_tdata[16:12] == 5'd0)
		else $error("data byte item also marks a close");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0)
		else $error("non-data item carries a byte");

	a_skid: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output");

endmodule

bind csv_field_splitter csvfs_checker u_csvfs_checker (.*);

`default_nettype wire

### tb/tb_csv_field_splitter.sv
// ----------------------------------------------------------------------------
// tb_csv_field_splitter
// Self-checking testbench of the CSV field splitter. A short table of
// directed items comes first: an empty line, byte extremes, quoted and
// unquoted fields, doubled quotes and the field limit. Random CSV lines
// follow, most well formed and some noise, under several field limits and
// with sender gaps and receiver stalls. Every output item is compared
// field by field with a predictor beside the stream or a row's result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_csv_field_splitter;

	timeunit 1ns;
	timeprecision 1ps;

	import csvfs_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int SETTLE_CYCLES = 8;
	localparam int ITEMS_PER_SETTING = 225;

	typedef enum logic [2:0] {
		AT_FIELD_START,
		IN_PLAIN,
		IN_QUOTES,
		QUOTE_SEEN,
		AFTER_CLOSE,
		IGNORE_REST
	} split_phase_e;

	typedef struct packed {
		logic [7:0] ch;
		logic       eol;
		bit         set_limit;
		logic [4:0] limit;
		bit         typed;
		res_t       want;
	} row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [4:0]          cfg_data = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = '0;
	logic                s_tlast = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [DATA_W-1:0]   m_tdata;
	logic [USER_W-1:0]   m_tuser;
	logic                m_tlast;

	// predictor state
	logic [4:0]          max_fields_reg;
	split_phase_e        phase;
	logic [4:0]          closed;

	res_t                field_q[$];
	int                  sender_pct = 0;
	int                  stall_pct = 0;
	int                  errors = 0;
	int                  counted = 0;
	int                  lines = 0;
	int                  checked = 0;
	int                  settings = 0;
	int                  cycles = 0;

	csv_field_splitter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_csv_field_splitter: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic res_t mk_res(input logic [7:0] b, input logic bv, input logic [3:0] idx,
			input logic fe, input logic le, input logic [4:0] cnt);
		res_t r;
		r.field_byte  = b;
		r.byte_valid  = bv;
		r.field_index = idx;
		r.field_end   = fe;
		r.line_end    = le;
		r.field_count = cnt;
		return r;
	endfunction

	function automatic row_t mk_row(input logic [7:0] ch, input logic eol, input bit set_limit,
			input logic [4:0] limit, input bit typed, input res_t want);
		row_t w;
		w.ch        = ch;
		w.eol       = eol;
		w.set_limit = set_limit;
		w.limit     = limit;
		w.typed     = typed;
		w.want      = want;
		return w;
	endfunction

	function automatic res_t close_field();
		res_t r;
		logic [4:0] lim;
		lim = (max_fields_reg == 5'd0) ? 5'd1 :
		      (max_fields_reg > 5'(FIELD_LIMIT)) ? 5'(FIELD_LIMIT) : max_fields_reg;
		r = mk_res(8'h00, 1'b0, closed[3:0], 1'b1, 1'b0, 5'd0);
		closed = closed + 5'd1;
		phase = (closed >= lim) ? IGNORE_REST : AT_FIELD_START;
		return r;
	endfunction

	function automatic bit split_byte(input logic [7:0] c, input logic eol, output res_t r);
		r = '0;
		if (eol) begin
			if (phase == IGNORE_REST)
				r = mk_res(8'h00, 1'b0, 4'd0, 1'b0, 1'b1, closed);
			else
				r = mk_res(8'h00, 1'b0, closed[3:0], 1'b1, 1'b1, closed + 5'd1);
			phase = AT_FIELD_START;
			closed = 5'd0;
			return 1'b1;
		end
		case (phase)
			AT_FIELD_START: begin
				if (c == CH_QUOTE) begin
					phase = IN_QUOTES;
					return 1'b0;
				end
				if (c == CH_COMMA) begin
					r = close_field();
					return 1'b1;
				end
				phase = IN_PLAIN;
				r = mk_res(c, 1'b1, closed[3:0], 1'b0, 1'b0, 5'd0);
				return 1'b1;
			end
			IN_PLAIN: begin
				if (c == CH_COMMA)
					r = close_field();
				else
					r = mk_res(c, 1'b1, closed[3:0], 1'b0, 1'b0, 5'd0);
				return 1'b1;
			end
			IN_QUOTES: begin
				if (c == CH_QUOTE) begin
					phase = QUOTE_SEEN;
					return 1'b0;
				end
				r = mk_res(c, 1'b1, closed[3:0], 1'b0, 1'b0, 5'd0);
				return 1'b1;
			end
			QUOTE_SEEN: begin
				if (c == CH_QUOTE) begin
					phase = IN_QUOTES;
					r = mk_res(c, 1'b1, closed[3:0], 1'b0, 1'b0, 5'd0);
					return 1'b1;
				end
				if (c == CH_COMMA) begin
					r = close_field();
					return 1'b1;
				end
				phase = AFTER_CLOSE;
				return 1'b0;
			end
			AFTER_CLOSE: begin
				if (c == CH_COMMA) begin
					r = close_field();
					return 1'b1;
				end
				return 1'b0;
			end
			default: begin
				phase = IGNORE_REST;
				return 1'b0;
			end
		endcase
	endfunction

	task automatic send_item(input logic [7:0] b, input logic eol, input bit typed,
			input res_t want);
		res_t r;
		bit   has;
		while (sender_pct != 0 && $urandom_range(0, 99) < sender_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eol;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (eol || phase != IGNORE_REST)
			counted++;
		if (eol)
			lines++;
		has = split_byte(b, eol, r);
		if (typed)
			field_q.push_back(want);
		else if (has)
			field_q.push_back(r);
	endtask

	task automatic drain(input int extra);
		s_tvalid <= 1'b0;
		while (field_q.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_limit(input logic [4:0] v);
		drain(SETTLE_CYCLES);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		max_fields_reg = v;
		settings++;
	endtask

	function automatic logic [7:0] any_but(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] v;
		v = 8'($urandom_range(0, 255));
		while (v == a || v == b)
			v = 8'($urandom_range(0, 255));
		return v;
	endfunction

	task automatic send_line(input bit noisy);
		logic [7:0] bytes[$];
		int         nf;
		int         len;
		int         pick;
		bit         quoted;
		if (noisy) begin
			len = $urandom_range(0, 20);
			repeat (len) begin
				pick = $urandom_range(0, 3);
				bytes.push_back(pick == 0 ? CH_QUOTE : pick == 1 ? CH_COMMA :
				                8'($urandom_range(0, 255)));
			end
		end else begin
			nf = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 18) : $urandom_range(1, 5);
			for (int f = 0; f < nf; f++) begin
				if (f > 0)
					bytes.push_back(CH_COMMA);
				quoted = ($urandom_range(0, 2) != 0);
				len = $urandom_range(0, 6);
				if (!quoted) begin
					for (int k = 0; k < len; k++)
						bytes.push_back(k == 0 ? any_but(CH_QUOTE, CH_COMMA) :
						                any_but(CH_COMMA, CH_COMMA));
				end else begin
					bytes.push_back(CH_QUOTE);
					for (int k = 0; k < len; k++) begin
						pick = $urandom_range(0, 99);
						if (pick < 15) begin
							bytes.push_back(CH_QUOTE);
							bytes.push_back(CH_QUOTE);
						end else if (pick < 30) begin
							bytes.push_back(CH_COMMA);
						end else begin
							bytes.push_back(any_but(CH_QUOTE, CH_QUOTE));
						end
					end
					if (f != nf - 1 || $urandom_range(0, 19) != 0)
						bytes.push_back(CH_QUOTE);
					if ($urandom_range(0, 4) == 0)
						repeat ($urandom_range(1, 3))
							bytes.push_back(any_but(CH_COMMA, CH_COMMA));
				end
			end
		end
		foreach (bytes[i])
			send_item(bytes[i], 1'b0, 1'b0, '0);
		send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
	endtask

	always @(posedge clk) begin : monitor
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.field_byte  = m_tdata[7:0];
			got.field_index = m_tdata[11:8];
			got.field_count = m_tdata[16:12];
			got.byte_valid  = m_tuser[0];
			got.field_end   = m_tuser[1];
			got.line_end    = m_tlast;
			if (m_tdata[DATA_W-1:17] !== '0) begin
				$error("tdata pad: expected 0, got %0h", m_tdata[DATA_W-1:17]);
				errors++;
			end
			if (field_q.size() == 0) begin
				$error("unexpected item: tdata %0h tuser %0b tlast %0b", m_tdata, m_tuser, m_tlast);
				errors++;
			end else begin
				want = field_q.pop_front();
				checked++;
				if (got.field_byte !== want.field_byte) begin
					$error("field_byte: expected %0h, got %0h", want.field_byte, got.field_byte);
					errors++;
				end
				if (got.byte_valid !== want.byte_valid) begin
					$error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
					errors++;
				end
				if (got.field_index !== want.field_index) begin
					$error("field_index: expected %0d, got %0d", want.field_index,
					       got.field_index);
					errors++;
				end
				if (got.field_end !== want.field_end) begin
					$error("field_end: expected %0b, got %0b", want.field_end, got.field_end);
					errors++;
				end
				if (got.line_end !== want.line_end) begin
					$error("line_end: expected %0b, got %0b", want.line_end, got.line_end);
					errors++;
				end
				if (got.field_count !== want.field_count) begin
					$error("field_count: expected %0d, got %0d", want.field_count,
					       got.field_count);
					errors++;
				end
			end
		end
	end

	initial begin : main
		row_t       rows[$];
		logic [4:0] limits[8];
		int         target;
		res_t       none;
		bit         paused;
		none = '0;
		paused = 1'b0;
		rows.push_back(mk_row(8'h00, 1'b1, 0, 5'd0, 1, mk_res(8'h00, 0, 4'd0, 1, 1, 5'd1)));
		rows.push_back(mk_row(8'h61, 1'b0, 0, 5'd0, 0, none));
		rows.push_back(mk_row(8'h00, 1'b0, 0, 5'd0, 0, none));
		rows.push_back(mk_row(8'hFF, 1'b0, 0, 5'd0, 0, none));
		rows.push_back(mk_row(CH_COMMA, 1'b0, 0, 5'd0, 1, mk_res(8'h00, 0, 4'd0, 1, 0, 5'd0)));
		rows.push_back(mk_row(CH_QUOTE, 1'b0, 0, 5'd0, 0, none));
		rows.push_back(mk_row(CH_COMMA, 1'b0, 0, 5'd0, 0, none));
		rows.push_back(mk_row(CH_QUOTE, 1'b0, 0, 5'd0, 0, none));
		rows.push_back(mk_row(CH_QUOTE, 1'b0, 0, 5'd0, 0, none));
		rows.push_back(mk_row(CH_QUOTE, 1'b0, 0, 5'd0, 0, none));
		rows.push_back(mk_row(8'h78, 1'b0, 0, 5'd0, 0, none));
		rows.push_back(mk_row(CH_QUOTE, 1'b0, 0, 5'd0, 0, none));
		rows.push_back(mk_row(CH_COMMA, 1'b0, 0, 5'd0, 0, none));
		rows.push_back(mk_row(CH_QUOTE, 1'b0, 0, 5'd0, 0, none));
		rows.push_back(mk_row(CH_QUOTE, 1'b0, 0, 5'd0, 0, none));
		rows.push_back(mk_row(CH_COMMA, 1'b0, 0, 5'd0, 0, none));
		rows.push_back(mk_row(8'h6B, 1'b0, 0, 5'd0, 0, none));
		rows.push_back(mk_row(CH_QUOTE, 1'b0, 0, 5'd0, 0, none));
		rows.push_back(mk_row(CH_COMMA, 1'b0, 0, 5'd0, 0, none));
		rows.push_back(mk_row(CH_QUOTE, 1'b0, 0, 5'd0, 0, none));
		rows.push_back(mk_row(8'h71, 1'b0, 0, 5'd0, 0, none));
		rows.push_back(mk_row(8'h00, 1'b1, 0, 5'd0, 0, none));
		rows.push_back(mk_row(CH_COMMA, 1'b0, 1, 5'd0, 1, mk_res(8'h00, 0, 4'd0, 1, 0, 5'd0)));
		rows.push_back(mk_row(8'h62, 1'b0, 0, 5'd0, 0, none));
		rows.push_back(mk_row(8'hFF, 1'b1, 0, 5'd0, 1, mk_res(8'h00, 0, 4'd0, 0, 1, 5'd1)));
		rows.push_back(mk_row(CH_QUOTE, 1'b0, 1, 5'd31, 0, none));
		rows.push_back(mk_row(8'h7A, 1'b0, 0, 5'd0, 0, none));
		rows.push_back(mk_row(CH_QUOTE, 1'b0, 0, 5'd0, 0, none));
		rows.push_back(mk_row(8'h00, 1'b1, 0, 5'd0, 1, mk_res(8'h00, 0, 4'd0, 1, 1, 5'd1)));

		limits = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd8, 5'd17, 5'($urandom_range(3, 15))};

		max_fields_reg = 5'd8;
		phase = AT_FIELD_START;
		closed = 5'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].set_limit)
				write_limit(rows[i].limit);
			send_item(rows[i].ch, rows[i].eol, rows[i].typed, rows[i].want);
		end

		for (int p = 0; p < 8; p++) begin
			sender_pct = 0;
			stall_pct = 0;
			write_limit(limits[p]);
			case (p % 4)
				1: sender_pct = 84;
				2: stall_pct = 84;
				3: begin
					sender_pct = 35;
					stall_pct = 35;
				end
				default: ;
			endcase
			target = counted + ITEMS_PER_SETTING;
			while (counted < target) begin
				send_line($urandom_range(0, 99) < 15);
				// hold off until the output side is empty
				if (p == 1 && !paused && counted >= target - ITEMS_PER_SETTING / 2 &&
				    checked > 0) begin
					drain(0);
					paused = 1'b1;
				end
			end
		end

		stall_pct = 0;
		drain(SETTLE_CYCLES + 2);
		$display("Sent %0d counted items in %0d lines under %0d field-limit writes;",
		         counted, lines, settings);
		$display("checked %0d output items with gaps and stalls, %0d mismatches.",
		         checked, errors);
		if (errors == 0)
			$display("tb_csv_field_splitter: PASS");
		else
			$display("tb_csv_field_splitter: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
rtl/csvfs_pkg.sv
rtl/csvfs_parser.sv
rtl/csvfs_out_buf.sv
rtl/csv_field_splitter.sv
rtl/csvfs_checker.sv
tb/tb_csv_field_splitter.sv
